[rtl/sem_pkg.sv]
`timescale 1ns / 1ps

package sem_pkg;

    // Line store geometry.
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W     = 12;
    localparam int CMP_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int MIN_WIDTH = 3;

    // Pixel and arithmetic widths.
    localparam int PIX_W  = 8;
    localparam int GRAD_W = 12;   // signed Sobel sum, |g| <= 1020
    localparam int ABS_W  = 10;   // magnitude of a Sobel sum
    localparam int DIV5_MUL   = 205;  // floor(x * 205 / 1024) == x / 5 for x < 1024
    localparam int DIV5_SHIFT = 10;
    localparam int PROD_W = ABS_W + 8;
    localparam int Q_W    = 8;    // |g| / 5 <= 204
    localparam int SQ_W   = 2 * Q_W + 1;
    localparam int SQRT_STEPS = (SQ_W + 1) / 2;
    localparam int ROOT_W = SQRT_STEPS;
    localparam int STEP_W = $clog2(SQRT_STEPS);
    localparam int MAG_MAX = 255;

    // Per-pixel sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SCALE,
        ST_SQUARE,
        ST_LAUNCH,
        ST_ROOT,
        ST_EMIT
    } sem_state_t;

endpackage

[rtl/sem_sqrt.sv]
`timescale 1ns / 1ps

module sem_sqrt
    import sem_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [SQ_W-1:0]   operand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int RW = SQ_W + 1;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [RW-1:0]     bit_reg, bit_next;
    logic [RW-1:0]     trial;

    // One digit of the restoring square root per cycle.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        trial     = root_reg + bit_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(SQRT_STEPS - 1);
            rem_next  = RW'(operand);
            root_next = '0;
            bit_next  = RW'(1) << (2 * (SQRT_STEPS - 1));
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next  = rem_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath state.
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

[rtl/sobel_edge_magnitude_stream_top.sv]
// Sobel gradient magnitude over a grey pixel stream, one pixel at a time.
// A pixel that yields no word is stored and then done; one that yields a word
// passes the sum, scale, square and launch states, then waits on the nine-step
// square-root unit. The line store is read and written once per pixel.
// Reset (aresetn low, synchronous) clears counters, window and line width (640);
// the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_top
    import sem_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    // Configuration: line_width.
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    // Input stream.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel
    input  logic             s_tuser,   // [0] frame_start
    // Output stream.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] magnitude
    output logic             m_tlast    // end_of_line
);

    sem_state_t state_reg, state_next;

    logic [CFG_W-1:0]  width_reg;
    logic [CMP_W-1:0]  width_eff;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [1:0]        rows_reg, rows_next;
    logic [COL_W-1:0]  cur_col_reg;
    logic [1:0]        cur_rows_reg;
    logic [PIX_W-1:0]  pixel_reg;
    logic              last_reg;
    logic              produce;
    logic              last_now;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] line_rdata_reg;
    logic [COL_W-1:0]   rd_addr;
    logic [PIX_W-1:0]   win_reg [9];

    logic signed [GRAD_W-1:0] gx, gy;
    logic [ABS_W-1:0]  ax_reg, ay_reg;
    logic [PROD_W-1:0] px_prod, py_prod;
    logic [Q_W-1:0]    qx_reg, qy_reg;
    logic [SQ_W-1:0]   sq_sum_reg;

    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    logic              m_tvalid_reg;
    logic [7:0]        m_tdata_reg;
    logic              m_tlast_reg;

    logic accept;
    logic mem_rd_en;
    logic mem_wr_en;
    logic sqrt_start;
    logic load_out;
    logic out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Effective width: line_width clamped to the supported range.
    always_comb begin
        if (width_reg < CFG_W'(MIN_WIDTH)) begin
            width_eff = CMP_W'(MIN_WIDTH);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            width_eff = CMP_W'(MAX_WIDTH);
        end else begin
            width_eff = CMP_W'(width_reg);
        end
    end

    // A frame start restarts at column 0 of row 0.
    assign rd_addr = s_tuser ? '0 : col_reg;

    // Row end and result decision for the pixel being stored.
    assign last_now = (CMP_W'(cur_col_reg) + 1'b1) >= width_eff;
    assign produce  = (cur_rows_reg == 2'd2) && (cur_col_reg >= COL_W'(2));

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = produce ? ST_SUM : ST_IDLE;
            ST_SUM:    state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_SQUARE;
            ST_SQUARE: state_next = ST_LAUNCH;
            ST_LAUNCH: state_next = ST_ROOT;
            ST_ROOT:   if (sqrt_done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_wr_en  = 1'b0;
        sqrt_start = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                mem_rd_en = s_tvalid;
            end
            ST_READ:   mem_wr_en  = 1'b1;
            ST_LAUNCH: sqrt_start = 1'b1;
            ST_EMIT:   load_out   = out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Column and row counters advance once the pixel is stored.
    always_comb begin
        col_next  = col_reg;
        rows_next = rows_reg;
        if (mem_wr_en) begin
            if (last_now) begin
                col_next  = '0;
                rows_next = (cur_rows_reg == 2'd2) ? 2'd2 : cur_rows_reg + 2'd1;
            end else begin
                col_next  = cur_col_reg + 1'b1;
                rows_next = cur_rows_reg;
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            width_reg    <= CFG_W'(640);
            col_reg      <= '0;
            rows_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            col_reg   <= col_next;
            rows_reg  <= rows_next;
            if (cfg_wr_en) begin
                width_reg <= cfg_wr_data;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Captured pixel, its position, and the row-end flag.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pixel_reg    <= s_tdata;
            cur_col_reg  <= rd_addr;
            cur_rows_reg <= s_tuser ? 2'd0 : rows_reg;
        end
        if (mem_wr_en) begin
            last_reg <= last_now;
        end
    end

    // Line store: upper row in the high byte, middle row in the low byte.
    always_ff @(posedge aclk) begin
        if (mem_rd_en) begin
            line_rdata_reg <= line_mem[rd_addr];
        end
        if (mem_wr_en) begin
            line_mem[cur_col_reg] <= {line_rdata_reg[PIX_W-1:0], pixel_reg};
        end
    end

    // Window shifts left by one column as each pixel is stored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (mem_wr_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= line_rdata_reg[2*PIX_W-1:PIX_W];
            win_reg[5] <= line_rdata_reg[PIX_W-1:0];
            win_reg[8] <= pixel_reg;
        end
    end

    // Horizontal and vertical Sobel sums.
    always_comb begin
        gx = - $signed(GRAD_W'(win_reg[0])) + $signed(GRAD_W'(win_reg[2]))
             - ($signed(GRAD_W'(win_reg[3])) <<< 1) + ($signed(GRAD_W'(win_reg[5])) <<< 1)
             - $signed(GRAD_W'(win_reg[6])) + $signed(GRAD_W'(win_reg[8]));
        gy =   $signed(GRAD_W'(win_reg[0])) + ($signed(GRAD_W'(win_reg[1])) <<< 1)
             + $signed(GRAD_W'(win_reg[2])) - $signed(GRAD_W'(win_reg[6]))
             - ($signed(GRAD_W'(win_reg[7])) <<< 1) - $signed(GRAD_W'(win_reg[8]));
    end

    // Only magnitudes matter after truncating division, since both get squared.
    assign px_prod = PROD_W'(ax_reg) * PROD_W'(DIV5_MUL);
    assign py_prod = PROD_W'(ay_reg) * PROD_W'(DIV5_MUL);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SUM) begin
            ax_reg <= gx[GRAD_W-1] ? ABS_W'(-gx) : ABS_W'(gx);
            ay_reg <= gy[GRAD_W-1] ? ABS_W'(-gy) : ABS_W'(gy);
        end
        if (state_reg == ST_SCALE) begin
            qx_reg <= px_prod[DIV5_SHIFT +: Q_W];
            qy_reg <= py_prod[DIV5_SHIFT +: Q_W];
        end
        if (state_reg == ST_SQUARE) begin
            sq_sum_reg <= SQ_W'(qx_reg * qx_reg) + SQ_W'(qy_reg * qy_reg);
        end
    end

    sem_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .operand (sq_sum_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    // Output word register, saturated at the byte maximum.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= (sqrt_root > ROOT_W'(MAG_MAX)) ? 8'(MAG_MAX) : sqrt_root[7:0];
            m_tlast_reg <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The read state always follows an accepted word.
    a_read_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |-> $past(accept))
        else $error("read state entered without an accepted word");

    // The root unit finishes only while the sequencer waits for it.
    a_root_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside the wait state");

    // The row counter saturates at two completed rows.
    a_rows_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        rows_reg != 2'd3)
        else $error("row counter exceeded two");

    // Leaving the emit state always leaves a word in the output register.
    a_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free |=> m_tvalid_reg && state_reg == ST_IDLE)
        else $error("result lost when leaving the emit state");

endmodule

[verif/sobel_edge_magnitude_stream_checker.sv]
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_checker
    import sem_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] pixel
    input  logic             s_tuser,   // [0] frame_start
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [7:0]       m_tdata,   // [7:0] magnitude
    input  logic             m_tlast,   // end_of_line
    output int               mismatch_count,
    output int               words_pending,
    output int               words_checked,
    output int               line_ends_checked
);

    typedef struct packed {
        logic [PIX_W-1:0] magnitude;
        logic             end_of_line;
    } edge_word_t;

    // Shadow copy of the line stores, the 3x3 window and the raster position.
    logic [PIX_W-1:0] row_two_up [MAX_WIDTH];
    logic [PIX_W-1:0] row_one_up [MAX_WIDTH];
    logic [PIX_W-1:0] window [9];
    int               column;
    int               rows_done;
    logic [CFG_W-1:0] line_width;

    edge_word_t       expected_edges [$];
    int               errors;
    int               checked;
    int               line_ends;

    // Floor square root, built one result bit at a time from the top down.
    function automatic logic [8:0] floor_sqrt(input int unsigned value);
        logic [8:0] root;
        logic [8:0] trial;
        root = '0;
        for (int b = 8; b >= 0; b--) begin
            trial = root | (9'd1 << b);
            if (int'(trial) * int'(trial) <= value) root = trial;
        end
        return root;
    endfunction

    // Moves one pixel through the shadow state and queues the magnitude word
    // it produces, if the window is complete.
    task automatic take_pixel(input logic [PIX_W-1:0] pixel, input logic frame_start);
        int               eff_width;
        int               gx;
        int               gy;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic             line_end;
        logic [8:0]       root;
        edge_word_t       word;

        eff_width = (line_width < MIN_WIDTH) ? MIN_WIDTH :
                    (line_width > MAX_WIDTH) ? MAX_WIDTH : int'(line_width);
        if (frame_start) begin
            column    = 0;
            rows_done = 0;
        end

        // The column slot rotates: middle row moves up, the new pixel becomes middle.
        top_px = row_two_up[column];
        mid_px = row_one_up[column];
        row_two_up[column] = mid_px;
        row_one_up[column] = pixel;

        for (int r = 0; r < 3; r++) begin
            window[3*r]     = window[3*r + 1];
            window[3*r + 1] = window[3*r + 2];
        end
        window[2] = top_px;
        window[5] = mid_px;
        window[8] = pixel;

        line_end = (column + 1 >= eff_width);

        if (rows_done >= 2 && column >= 2) begin
            gx = (int'(window[2]) + 2 * int'(window[5]) + int'(window[8]))
               - (int'(window[0]) + 2 * int'(window[3]) + int'(window[6]));
            gy = (int'(window[0]) + 2 * int'(window[1]) + int'(window[2]))
               - (int'(window[6]) + 2 * int'(window[7]) + int'(window[8]));
            // Integer division truncates toward zero, as the scaling requires.
            gx = gx / 5;
            gy = gy / 5;
            root = floor_sqrt(gx * gx + gy * gy);
            word.magnitude   = (root > 9'(MAG_MAX)) ? PIX_W'(MAG_MAX) : root[PIX_W-1:0];
            word.end_of_line = line_end;
            expected_edges.push_back(word);
        end

        if (line_end) begin
            column = 0;
            if (rows_done < 2) rows_done++;
        end else begin
            column++;
        end
    endtask

    // Watch both channels and the register port on every rising edge.
    always @(posedge aclk) begin : monitor
        edge_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                row_two_up[i] = '0;
                row_one_up[i] = '0;
            end
            for (int i = 0; i < 9; i++) window[i] = '0;
            column     = 0;
            rows_done  = 0;
            line_width = CFG_W'(640);
            expected_edges.delete();
        end else begin
            // Compare the outgoing word before predicting from a pixel taken
            // at the same edge, which cannot have produced it yet.
            if (m_tvalid && m_tready) begin
                if (expected_edges.size() == 0) begin
                    $error("magnitude word with none expected: magnitude %0d, end_of_line %0b",
                           m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = expected_edges.pop_front();
                    checked++;
                    if (m_tlast) line_ends++;
                    if (m_tdata !== want.magnitude) begin
                        $error("magnitude: expected %0d, actual %0d", want.magnitude, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== want.end_of_line) begin
                        $error("end_of_line: expected %0b, actual %0b",
                               want.end_of_line, m_tlast);
                        errors++;
                    end
                end
            end
            if (cfg_wr_en) line_width = cfg_wr_data;
            if (s_tvalid && s_tready) take_pixel(s_tdata, s_tuser);
        end
        mismatch_count    <= errors;
        words_pending     <= expected_edges.size();
        words_checked     <= checked;
        line_ends_checked <= line_ends;
    end

endmodule

[verif/sobel_edge_magnitude_stream_top_test.sv]
`timescale 1ns / 1ps

module sobel_edge_magnitude_stream_top_test
    import sem_pkg::*;
();

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int RANDOM_PIXELS = 340;
    localparam int QUIET_TAIL    = 60;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_SLACK   = 24;
    localparam int STALL_LIMIT   = 3000;
    localparam int WIDE_PIXELS   = 24;
    localparam int PRESSURE_ROWS = 5;

    // Hand-built frames at the smallest width: a strong edge, then a frame
    // start mid-row, followed by an edge with a negative horizontal sum.
    localparam int               EDGE_COUNT = 19;
    localparam logic [7:0] EDGE_PIXELS [EDGE_COUNT] = '{
        8'd0,   8'd255, 8'd255,
        8'd0,   8'd0,   8'd255,
        8'd0,   8'd0,   8'd255,
        8'd17,
        8'd255, 8'd255, 8'd0,
        8'd255, 8'd255, 8'd0,
        8'd0,   8'd0,   8'd0
    };

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;   // [7:0] pixel
    logic             s_tuser;   // [0] frame_start
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;   // [7:0] magnitude
    logic             m_tlast;   // end_of_line

    int mismatch_count;
    int words_pending;
    int words_checked;
    int line_ends_checked;

    bit quiet_tail;
    bit hold_request;
    bit hold_served;
    int pixels_sent;
    int width_writes;
    int cur_width;

    sobel_edge_magnitude_stream_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    sobel_edge_magnitude_stream_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .words_pending     (words_pending),
        .words_checked     (words_checked),
        .line_ends_checked (line_ends_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Offers one pixel word, sometimes after a short gap, and returns at the
    // edge where it is taken. Valid stays high so back-to-back words need
    // no second assignment in the same step.
    task automatic send_pixel(input logic [7:0] pixel, input logic frame_start);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pixel;
        s_tuser  <= frame_start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    // Random pixels, with a bias toward black and white for hard edges.
    task automatic send_random_pixels(input int count, input bit new_frame);
        logic [7:0] pixel;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            else pixel = 8'($urandom);
            send_pixel(pixel, new_frame && i == 0);
        end
    endtask

    // Waits until every predicted word has come out and the block has had
    // time to finish a pixel that yields no word.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_line_width(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        width_writes++;
        cur_width = (value < MIN_WIDTH) ? MIN_WIDTH :
                    (value > MAX_WIDTH) ? MAX_WIDTH : int'(value);
    endtask

    // Result sink: random back-pressure, plus one long hold-off that lets the
    // block fill up and stall its input.
    initial begin : result_sink
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_request && !hold_served) begin
                hold_served = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
        end
    end

    // Watchdog: ends the run if no word moves for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int new_width;
        int rows;
        int total;
        int split;
        int random_start;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cur_width   = 640;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero width behaves as the minimum of three columns.
        write_line_width('0);
        for (int i = 0; i < EDGE_COUNT; i++) begin
            send_pixel(EDGE_PIXELS[i], i == 0 || i == 10);
        end
        drain_block();

        // Stream a small frame while the result side is held off, so that the
        // output register and the sequencer both hold a word and input stalls.
        hold_request = 1'b1;
        wait (hold_served);
        send_random_pixels(PRESSURE_ROWS * cur_width, 1'b1);
        drain_block();

        // The largest register value clamps to the full line store; a partial
        // row at that width.
        write_line_width('1);
        send_random_pixels(WIDE_PIXELS, 1'b1);
        drain_block();

        // Random frames at mostly small widths, some cut short, some with a
        // width reduction partway through.
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_PIXELS) begin
            case ($urandom_range(0, 7))
                0:       new_width = $urandom_range(0, MIN_WIDTH - 1);
                1:       new_width = $urandom_range(13, 40);
                default: new_width = $urandom_range(MIN_WIDTH, 12);
            endcase
            drain_block();
            write_line_width(CFG_W'(new_width));
            repeat ($urandom_range(1, 2)) begin
                rows  = $urandom_range(3, 5);
                total = rows * cur_width;
                if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total - 1);
                if ($urandom_range(0, 3) == 0) begin
                    // Pause in mid-frame, shrink the row, and carry on.
                    split = $urandom_range(1, total - 1);
                    send_random_pixels(split, 1'b1);
                    drain_block();
                    write_line_width(CFG_W'($urandom_range(0, cur_width)));
                    send_random_pixels($urandom_range(1, 3) * cur_width
                                       + $urandom_range(0, 2), 1'b0);
                end else begin
                    send_random_pixels(total, 1'b1);
                end
                quiet_tail = (pixels_sent - random_start >= RANDOM_PIXELS - QUIET_TAIL);
            end
        end
        drain_block();

        $display("Streamed %0d pixels through %0d line width settings, from below the minimum",
                 pixels_sent, width_writes);
        $display("to beyond the line store; %0d magnitude words compared, %0d closing a row.",
                 words_checked, line_ends_checked);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
